/* sv/lisl_pkg.sv */
// Shared types and constants of the learned index segment lookup.
package lisl_pkg;

	localparam int DEF_MAX_SEGMENTS  = 1024;
	localparam int DEF_FRACTION_BITS = 16;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_BOUND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_CNT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MERGED    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NB_CLAMP  = 3'd6;

	// One item as it travels down the search levels. For a table write the
	// key field carries the start key of the written segment.
	typedef struct packed {
		logic        vld;
		logic        lookup;
		logic        miss;
		logic [63:0] key;
		logic [9:0]  tbl_idx;
		logic [63:0] slope;
		logic [63:0] icpt;
		logic [31:0] last_pos;
	} lisl_item_t;

	// Control bits that follow an item through the arithmetic stages.
	typedef struct packed {
		logic vld;
		logic lookup;
		logic miss;
	} lisl_ctl_t;

endpackage

/* sv/lisl_search_level.sv */
// One level of the pipelined binary search, with its own copy of the start keys.
module lisl_search_level #(
	parameter int MAX_SEGMENTS = lisl_pkg::DEF_MAX_SEGMENTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lisl_pkg::lisl_item_t              item_in,
	input  logic [$clog2(MAX_SEGMENTS)-1:0]   left_in,
	input  logic [$clog2(MAX_SEGMENTS)-1:0]   right_in,
	output lisl_pkg::lisl_item_t              item_out,
	output logic [$clog2(MAX_SEGMENTS)-1:0]   left_out,
	output logic [$clog2(MAX_SEGMENTS)-1:0]   right_out
);
	import lisl_pkg::*;

	localparam int IDX_W = $clog2(MAX_SEGMENTS);

	logic [63:0]    key_mem [MAX_SEGMENTS];
	logic [IDX_W:0] mid_sum;
	logic [IDX_W-1:0] mid;
	logic           act;
	logic [31:0]    wr_idx32;
	logic           wr_en;

	lisl_item_t     item_s1;
	logic [IDX_W-1:0] left_s1;
	logic [IDX_W-1:0] right_s1;
	logic [IDX_W-1:0] mid_s1;
	logic           act_s1;
	logic [63:0]    rd_s1;
	logic           go_left;

	assign mid_sum  = {1'b0, left_in} + {1'b0, right_in};
	assign mid      = mid_sum[IDX_W:1];
	assign act      = (left_in + 1'b1) != right_in;
	assign wr_idx32 = 32'(item_in.tbl_idx);
	assign wr_en    = item_in.vld && !item_in.lookup && (wr_idx32 < 32'(MAX_SEGMENTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx32[IDX_W-1:0]] <= item_in.key;
		end
		rd_s1 <= key_mem[mid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.vld <= 1'b0;
		end else begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk) begin
		left_s1  <= left_in;
		right_s1 <= right_in;
		mid_s1   <= mid;
		act_s1   <= act;
	end

	assign go_left   = item_s1.key < rd_s1;
	assign item_out  = item_s1;
	assign left_out  = (act_s1 && !go_left) ? mid_s1 : left_s1;
	assign right_out = (act_s1 && go_left) ? mid_s1 : right_s1;

	a_mid_inside: assert property (@(posedge clk) disable iff (!arst_n)
		item_s1.vld && item_s1.lookup && act_s1 |-> mid_s1 > left_s1 && mid_s1 < right_s1)
		else $error("search midpoint outside the open range");
	a_range_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		item_s1.vld && item_s1.lookup |-> left_out >= left_s1 && right_out <= right_s1)
		else $error("search range grew");
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		item_s1.vld && item_s1.lookup |-> left_out < right_out)
		else $error("search range collapsed");

endmodule

/* sv/learned_index_segment_lookup.sv */
// Top level of the piecewise linear learned index lookup.
// The item passes one search level per index bit, then a memory read, a split 64x64
// multiply and the bound and clamp stages; done rises with the registered result.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset clears the pipeline valid bits and loads the register defaults; the segment
// table is not cleared and must be written before it is looked up.
module learned_index_segment_lookup #(
	parameter int MAX_SEGMENTS  = lisl_pkg::DEF_MAX_SEGMENTS,
	parameter int FRACTION_BITS = lisl_pkg::DEF_FRACTION_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [9:0]                     table_index,
	input  logic [63:0]                    start_key,
	input  logic [63:0]                    slope,
	input  logic signed [63:0]             intercept,
	input  logic [31:0]                    last_position,
	input  logic [63:0]                    lookup_key,
	output logic                           done,
	output logic [31:0]                    lower_position,
	output logic [31:0]                    upper_position,
	output logic                           not_found,
	output logic [9:0]                     segment_found,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lisl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import lisl_pkg::*;

	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int SF    = 64 - FRACTION_BITS;  // fraction bits of the slope
	localparam int FL_W  = 66;

	// Configuration registers. The user must change them only while no item is in flight; the block does not enforce it.
	logic [63:0] min_key_q, max_key_q;
	logic [31:0] entry_cnt_q;
	logic [15:0] err_bound_q;
	logic [10:0] seg_cnt_q;
	logic        merged_q, nb_clamp_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_key_q   <= '0;
			max_key_q   <= '1;
			entry_cnt_q <= 32'd1;
			err_bound_q <= 16'd8;
			seg_cnt_q   <= 11'd2;
			merged_q    <= 1'b0;
			nb_clamp_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_KEY:   min_key_q   <= cfg_data;
				CFG_MAX_KEY:   max_key_q   <= cfg_data;
				CFG_ENTRY_CNT: entry_cnt_q <= cfg_data[31:0];
				CFG_ERR_BOUND: err_bound_q <= cfg_data[15:0];
				CFG_SEG_CNT:   seg_cnt_q   <= cfg_data[10:0];
				CFG_MERGED:    merged_q    <= cfg_data[0];
				CFG_NB_CLAMP:  nb_clamp_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Item entry. The search starts on the range [0, count-1], where the
	// segment count is pulled into [2, MAX_SEGMENTS]. The key bounds are
	// checked here and the verdict rides along with the item.
	lisl_item_t  item_in;
	logic [31:0] cnt32;
	logic [31:0] right32;

	always_comb begin
		cnt32 = 32'(seg_cnt_q);
		if (cnt32 < 32'd2) begin
			cnt32 = 32'd2;
		end
		if (cnt32 > 32'(MAX_SEGMENTS)) begin
			cnt32 = 32'(MAX_SEGMENTS);
		end
		right32 = cnt32 - 32'd1;
	end

	assign item_in.vld      = start && !busy;
	assign item_in.lookup   = req_type;
	assign item_in.miss     = (lookup_key > max_key_q) || (lookup_key < min_key_q);
	assign item_in.key      = req_type ? lookup_key : start_key;
	assign item_in.tbl_idx  = table_index;
	assign item_in.slope    = slope;
	assign item_in.icpt     = intercept;
	assign item_in.last_pos = last_position;

	// Binary search: one registered level per index bit, each with its own copy of the start keys.
	// A write item passes each level in order, so lookups behind it see the
	// new entry and lookups ahead of it do not.
	lisl_item_t       lvl_item  [IDX_W+1];
	logic [IDX_W-1:0] lvl_left  [IDX_W+1];
	logic [IDX_W-1:0] lvl_right [IDX_W+1];

	assign lvl_item[0]  = item_in;
	assign lvl_left[0]  = '0;
	assign lvl_right[0] = right32[IDX_W-1:0];

	for (genvar j = 0; j < IDX_W; j++) begin : g_level
		lisl_search_level #(
			.MAX_SEGMENTS(MAX_SEGMENTS)
		) u_level (
			.clk      (clk),
			.arst_n   (arst_n),
			.item_in  (lvl_item[j]),
			.left_in  (lvl_left[j]),
			.right_in (lvl_right[j]),
			.item_out (lvl_item[j+1]),
			.left_out (lvl_left[j+1]),
			.right_out(lvl_right[j+1])
		);
	end

	lisl_item_t       sitem;
	logic [IDX_W-1:0] sleft;
	logic [31:0]      swr_idx32;
	logic             swr_en;

	assign sitem     = lvl_item[IDX_W];
	assign sleft     = lvl_left[IDX_W];
	assign swr_idx32 = 32'(sitem.tbl_idx);
	assign swr_en    = sitem.vld && !sitem.lookup && (swr_idx32 < 32'(MAX_SEGMENTS));

	// Stage 1: segment parameters of the chosen segment and the last position
	// of its predecessor, from a second copy of that column.
	logic [63:0] slope_mem [MAX_SEGMENTS];
	logic [63:0] icpt_mem  [MAX_SEGMENTS];
	logic [31:0] last_mem  [MAX_SEGMENTS];
	logic [31:0] prev_mem  [MAX_SEGMENTS];

	lisl_ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic [IDX_W-1:0] left_s1, left_s2, left_s3, left_s4, left_s5, left_s6, left_s7,
		left_s8;
	logic [31:0]      last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7,
		last_s8;
	logic [31:0]      prev_s1, prev_s2, prev_s3, prev_s4, prev_s5, prev_s6, prev_s7,
		prev_s8;
	logic [63:0]      key_s1, slope_s1, icpt_s1, icpt_s2, icpt_s3, icpt_s4;

	always_ff @(posedge clk) begin
		if (swr_en) begin
			slope_mem[swr_idx32[IDX_W-1:0]] <= sitem.slope;
			icpt_mem[swr_idx32[IDX_W-1:0]]  <= sitem.icpt;
			last_mem[swr_idx32[IDX_W-1:0]]  <= sitem.last_pos;
			prev_mem[swr_idx32[IDX_W-1:0]]  <= sitem.last_pos;
		end
		slope_s1 <= slope_mem[sleft];
		icpt_s1  <= icpt_mem[sleft];
		last_s1  <= last_mem[sleft];
		prev_s1  <= prev_mem[sleft - 1'b1];
		key_s1   <= sitem.key;
		left_s1  <= sleft;
	end

	// Control valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s1 <= '{vld: sitem.vld, lookup: sitem.lookup, miss: sitem.miss};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		left_s2 <= left_s1;
		left_s3 <= left_s2;
		left_s4 <= left_s3;
		left_s5 <= left_s4;
		left_s6 <= left_s5;
		left_s7 <= left_s6;
		left_s8 <= left_s7;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		last_s5 <= last_s4;
		last_s6 <= last_s5;
		last_s7 <= last_s6;
		last_s8 <= last_s7;
		prev_s2 <= prev_s1;
		prev_s3 <= prev_s2;
		prev_s4 <= prev_s3;
		prev_s5 <= prev_s4;
		prev_s6 <= prev_s5;
		prev_s7 <= prev_s6;
		prev_s8 <= prev_s7;
		icpt_s2 <= icpt_s1;
		icpt_s3 <= icpt_s2;
		icpt_s4 <= icpt_s3;
	end

	// Stages 2 to 4: key * slope as four 32x32 partial products, the middle
	// terms summed, then the full 128-bit product.
	logic [63:0]  pp_ll_s2, pp_hl_s2, pp_lh_s2, pp_hh_s2;
	logic [64:0]  pp_mid_s3;
	logic [63:0]  pp_ll_s3, pp_hh_s3;
	logic [127:0] prod_s4;

	always_ff @(posedge clk) begin
		pp_ll_s2  <= 64'(key_s1[31:0])  * 64'(slope_s1[31:0]);
		pp_hl_s2  <= 64'(key_s1[63:32]) * 64'(slope_s1[31:0]);
		pp_lh_s2  <= 64'(key_s1[31:0])  * 64'(slope_s1[63:32]);
		pp_hh_s2  <= 64'(key_s1[63:32]) * 64'(slope_s1[63:32]);
		pp_mid_s3 <= {1'b0, pp_hl_s2} + {1'b0, pp_lh_s2};
		pp_ll_s3  <= pp_ll_s2;
		pp_hh_s3  <= pp_hh_s2;
		prod_s4   <= {pp_hh_s3, pp_ll_s3} + {31'd0, pp_mid_s3, 32'd0};
	end

	// Stage 5: integer part of the product saturated at 2^62, integer part of
	// the intercept, the carry out of the two fractions and whether a fraction is left.
	logic          ovf;
	logic [63:0]   pint_raw;
	logic [62:0]   pint;
	logic [SF-1:0] fb;
	logic [SF:0]   fsum;
	logic [62:0]   pint_s5;
	logic [63:0]   bint_s5;
	logic          carry_s5, frac_s5;

	assign ovf      = |prod_s4[127:64+SF];
	assign pint_raw = prod_s4[64+SF-1:SF];
	assign pint     = (ovf || pint_raw > 64'h4000_0000_0000_0000) ?
		63'h4000_0000_0000_0000 : pint_raw[62:0];
	assign fb       = SF'(icpt_s4[FRACTION_BITS-1:0]) << (SF - FRACTION_BITS);
	assign fsum     = {1'b0, prod_s4[SF-1:0]} + {1'b0, fb};

	always_ff @(posedge clk) begin
		pint_s5  <= pint;
		bint_s5  <= 64'($signed(icpt_s4) >>> FRACTION_BITS);
		carry_s5 <= fsum[SF];
		frac_s5  <= |fsum[SF-1:0];
	end

	// Stage 6: floor of the prediction.
	logic signed [FL_W-1:0] fl_s6;
	logic                   frac_s6;

	always_ff @(posedge clk) begin
		fl_s6   <= $signed({3'b000, pint_s5}) + $signed({{2{bint_s5[63]}}, bint_s5})
			+ $signed({65'd0, carry_s5});
		frac_s6 <= frac_s5;
	end

	// Stage 7: widen by the error bound on both sides.
	logic signed [FL_W-1:0] e_ext;
	logic signed [FL_W-1:0] lo_diff, up_sum;
	logic                   lo_pos;
	logic [63:0]            lo_s7, up_s7;

	assign e_ext   = $signed({50'd0, err_bound_q});
	assign lo_pos  = (fl_s6 > e_ext) || (fl_s6 == e_ext && frac_s6);
	assign lo_diff = fl_s6 - e_ext;
	assign up_sum  = fl_s6 + e_ext + $signed({65'd0, frac_s6});

	always_ff @(posedge clk) begin
		lo_s7 <= lo_pos ? lo_diff[63:0] : 64'd0;
		up_s7 <= up_sum[FL_W-1] ? 64'd0 : up_sum[63:0];
	end

	// Stage 8: clamp to the entry count.
	logic [31:0] lastpos;
	logic [31:0] upper_s8, lower_s8;
	logic        lge_s8;

	assign lastpos = (entry_cnt_q != 32'd0) ? entry_cnt_q - 32'd1 : 32'd0;

	always_ff @(posedge clk) begin
		upper_s8 <= (up_s7 >= {32'd0, entry_cnt_q}) ? lastpos : up_s7[31:0];
		lower_s8 <= lo_s7[31:0];
		lge_s8   <= lo_s7 >= {32'd0, entry_cnt_q};
	end

	// Stage 9: lower bound repair in merged mode, otherwise the optional clamp to
	// the neighbouring segments; misses and writes get their fixed answers.
	logic [33:0] rep;
	logic [31:0] lower_n, upper_n;
	logic [31:0] left32;
	logic        miss_n;

	assign rep    = {2'b00, upper_s8} - {17'd0, err_bound_q, 1'b0} - 34'd1;
	assign left32 = 32'(left_s8);
	assign miss_n = ctl_s8.miss || (lge_s8 && !merged_q);

	always_comb begin
		lower_n = lower_s8;
		upper_n = upper_s8;
		if (lge_s8 && merged_q) begin
			lower_n = rep[33] ? 32'd0 : rep[31:0];
		end
		if (nb_clamp_q && !merged_q) begin
			if (left32 != 32'd0 && lower_n <= prev_s8) begin
				lower_n = (prev_s8 == 32'hFFFF_FFFF) ? prev_s8 : prev_s8 + 32'd1;
			end
			if (upper_n > last_s8) begin
				upper_n = last_s8;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s8.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl_s8.lookup) begin
			lower_position <= '0;
			upper_position <= '0;
			not_found      <= 1'b0;
			segment_found  <= '0;
		end else if (miss_n) begin
			lower_position <= entry_cnt_q;
			upper_position <= entry_cnt_q;
			not_found      <= 1'b1;
			segment_found  <= '0;
		end else begin
			lower_position <= lower_n;
			upper_position <= upper_n;
			not_found      <= 1'b0;
			segment_found  <= left32[9:0];
		end
	end

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && not_found |-> lower_position == entry_cnt_q && upper_position == entry_cnt_q)
		else $error("miss result does not report the entry count");
	a_miss_seg: assert property (@(posedge clk) disable iff (!arst_n)
		done && not_found |-> segment_found == 10'd0)
		else $error("miss result names a segment");
	a_upper_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		done && !not_found && entry_cnt_q != 32'd0 |-> upper_position < entry_cnt_q)
		else $error("upper position beyond the last entry");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the learned index segment lookup.
//
// An initial block plans the whole run as a queue of pending steps: segment
// table writes, key lookups, register writes and drain points. A clocked
// driver feeds that queue to the block, with bursts and random gaps on the
// item side, and runs the range predictor on every lookup that it transfers.
// A clocked monitor takes each result as it strobes and compares it, field by
// field, with the oldest expected range.
module testbench;

	import lisl_pkg::*;

	localparam int                   HALF_PERIOD = 4;
	localparam int                   MAX_SEGS    = DEF_MAX_SEGMENTS;
	localparam int                   FRAC        = DEF_FRACTION_BITS;
	// Time from a transfer until its result is taken; the settle times add margin.
	localparam int                   LATENCY     = 19;
	localparam int                   SETTLE      = LATENCY + 6;
	localparam int                   STALL_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
	localparam logic                 REQ_WRITE   = 1'b0;
	localparam logic                 REQ_LOOKUP  = 1'b1;
	localparam logic [63:0]          KEY_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]          INT_CAP     = 64'h4000_0000_0000_0000;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_e;

	typedef struct {
		step_kind_e           kind;
		logic                 req;
		logic [9:0]           idx;
		logic [63:0]          skey;
		logic [63:0]          slope;
		logic [63:0]          icpt;
		logic [31:0]          lpos;
		logic [63:0]          lkey;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [63:0]          cfg_data;
	} step_t;

	typedef struct packed {
		logic [31:0] lower;
		logic [31:0] upper;
		logic        miss;
		logic [9:0]  seg;
	} range_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 start         = 1'b0;
	logic                 busy;
	logic                 req_type      = 1'b0;
	logic [9:0]           table_index   = '0;
	logic [63:0]          start_key     = '0;
	logic [63:0]          slope         = '0;
	logic signed [63:0]   intercept     = '0;
	logic [31:0]          last_position = '0;
	logic [63:0]          lookup_key    = '0;
	logic                 done;
	logic [31:0]          lower_position;
	logic [31:0]          upper_position;
	logic                 not_found;
	logic [9:0]           segment_found;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [63:0]          cfg_data      = '0;

	learned_index_segment_lookup i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.table_index    (table_index),
		.start_key      (start_key),
		.slope          (slope),
		.intercept      (intercept),
		.last_position  (last_position),
		.lookup_key     (lookup_key),
		.done           (done),
		.lower_position (lower_position),
		.upper_position (upper_position),
		.not_found      (not_found),
		.segment_found  (segment_found),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Steps not yet transferred, and ranges predicted but not yet seen.
	step_t  pending_steps[$];
	range_t expected_ranges[$];

	// Shadow of the block's registers and segment table, updated on transfers.
	logic [63:0] cfg_min_key   = 64'd0;
	logic [63:0] cfg_max_key   = KEY_ONES;
	logic [31:0] cfg_entries   = 32'd1;
	logic [15:0] cfg_err       = 16'd8;
	logic [10:0] cfg_segs      = 11'd2;
	logic        cfg_merged    = 1'b0;
	logic        cfg_nbclamp   = 1'b0;
	logic [63:0] seg_key   [MAX_SEGS];
	logic [63:0] seg_slope [MAX_SEGS];
	logic [63:0] seg_icpt  [MAX_SEGS];
	logic [31:0] seg_last  [MAX_SEGS];

	// Table plan used while the stimulus is built.
	logic [63:0] plan_key  [MAX_SEGS];
	logic [31:0] plan_last [MAX_SEGS];
	logic [63:0] plan_min;
	logic [63:0] plan_max;

	int error_count;
	int write_count;
	int lookup_count;
	int cfg_count;
	int miss_count;
	int result_count;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Predicted search range for one key under the current shadow state. The
	// prediction slope*key+intercept is kept exact: the product carries 48
	// fraction bits and the intercept's 16 are lined up with them.
	function automatic range_t predict_range(logic [63:0] key);
		logic [127:0] prod;
		logic [63:0]  pint;
		logic [63:0]  size;
		logic [63:0]  lastpos;
		logic [63:0]  upper;
		logic [63:0]  lower;
		logic [48:0]  frac_sum;
		logic         frac;
		longint       bint;
		longint       fl;
		longint       lo;
		longint       up;
		longint       e;
		longint       t;
		int           cnt;
		int           lft;
		int           rgt;
		int           mid;
		range_t       res;

		size     = {32'd0, cfg_entries};
		lastpos  = (size != 0) ? size - 64'd1 : 64'd0;
		res.lower = cfg_entries;
		res.upper = cfg_entries;
		res.miss  = 1'b1;
		res.seg   = '0;
		if (key > cfg_max_key || key < cfg_min_key)
			return res;

		cnt = int'(cfg_segs);
		if (cnt < 2)
			cnt = 2;
		if (cnt > MAX_SEGS)
			cnt = MAX_SEGS;
		lft = 0;
		rgt = cnt - 1;
		while (lft != rgt - 1) begin
			mid = (lft + rgt) / 2;
			if (key < seg_key[mid])
				rgt = mid;
			else
				lft = mid;
		end

		prod = {64'd0, key} * {64'd0, seg_slope[lft]};
		if (prod[127:112] != 0) begin
			pint = INT_CAP;
		end else begin
			pint = prod[111:48];
			if (pint > INT_CAP)
				pint = INT_CAP;
		end
		bint     = longint'($signed(seg_icpt[lft])) >>> FRAC;
		frac_sum = {1'b0, prod[47:0]} + {1'b0, seg_icpt[lft][15:0], 32'd0};
		frac     = (frac_sum[47:0] != 0);
		fl       = longint'(pint) + bint + (frac_sum[48] ? 1 : 0);

		e = longint'({48'd0, cfg_err});
		if (fl > e || (fl == e && frac))
			lo = fl - e;
		else
			lo = 0;
		up = fl + (frac ? 1 : 0) + e;
		if (up < 0)
			up = 0;
		upper = up;
		if (upper >= size)
			upper = lastpos;
		lower = lo;

		// A lower bound past the end is either repaired or reported as a miss.
		if (lower >= size) begin
			if (cfg_merged) begin
				t     = longint'(upper) - 2 * e - 1;
				lower = (t < 0) ? 64'd0 : t;
			end else begin
				return res;
			end
		end

		if (cfg_nbclamp && !cfg_merged) begin
			if (lft != 0 && lower <= {32'd0, seg_last[lft-1]}) begin
				lower = {32'd0, seg_last[lft-1]} + 64'd1;
				if (lower > 64'hFFFF_FFFF)
					lower = 64'hFFFF_FFFF;
			end
			if (upper > {32'd0, seg_last[lft]})
				upper = {32'd0, seg_last[lft]};
		end

		res.lower = lower[31:0];
		res.upper = upper[31:0];
		res.miss  = 1'b0;
		res.seg   = lft[9:0];
		return res;
	endfunction

	// Applies one transferred item to the shadow state and queues its result.
	task automatic take_item(step_t s);
		range_t r;

		if (s.req == REQ_WRITE) begin
			seg_key[s.idx]   = s.skey;
			seg_slope[s.idx] = s.slope;
			seg_icpt[s.idx]  = s.icpt;
			seg_last[s.idx]  = s.lpos;
			write_count++;
			r = '0;
		end else begin
			r = predict_range(s.lkey);
			lookup_count++;
			if (r.miss)
				miss_count++;
		end
		expected_ranges.insert(expected_ranges.size(), r);
	endtask

	task automatic take_cfg(step_t s);
		cfg_count++;
		case (s.cfg_idx)
			CFG_MIN_KEY:   cfg_min_key = s.cfg_data;
			CFG_MAX_KEY:   cfg_max_key = s.cfg_data;
			CFG_ENTRY_CNT: cfg_entries = s.cfg_data[31:0];
			CFG_ERR_BOUND: cfg_err     = s.cfg_data[15:0];
			CFG_SEG_CNT:   cfg_segs    = s.cfg_data[10:0];
			CFG_MERGED:    cfg_merged  = s.cfg_data[0];
			CFG_NB_CLAMP:  cfg_nbclamp = s.cfg_data[0];
			default: ;
		endcase
	endtask

	// Driver. The head of the queue is presented until its transfer; the next
	// head follows in the same cycle unless a gap, a register write or a drain
	// point stands in the way.
	int    gap_left;
	int    burst_left;
	int    settle_left;
	bit    drive_item;
	bit    drive_cfg;
	step_t head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start         <= 1'b0;
			cfg_valid     <= 1'b0;
			req_type      <= 1'b0;
			table_index   <= '0;
			start_key     <= '0;
			slope         <= '0;
			intercept     <= '0;
			last_position <= '0;
			lookup_key    <= '0;
			cfg_index     <= '0;
			cfg_data      <= '0;
			gap_left      = 0;
			burst_left    = 8;
			settle_left   = SETTLE;
		end else begin
			if (start && !busy) begin
				take_item(pending_steps.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					// Roughly one burst in four runs on without a gap.
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					burst_left = $urandom_range(1, 40);
				end
			end
			if (cfg_valid && cfg_ready)
				take_cfg(pending_steps.pop_front());

			drive_item = start && busy;
			drive_cfg  = cfg_valid && !cfg_ready;
			if (!drive_item && !drive_cfg && pending_steps.size() > 0) begin
				case (pending_steps[0].kind)
					STEP_DRAIN: begin
						if (expected_ranges.size() != 0) begin
							settle_left = SETTLE;
						end else if (settle_left > 0) begin
							settle_left--;
						end else begin
							void'(pending_steps.pop_front());
							settle_left = SETTLE;
						end
					end
					STEP_CFG: begin
						drive_cfg = 1'b1;
					end
					default: begin
						if (gap_left > 0)
							gap_left--;
						else
							drive_item = 1'b1;
					end
				endcase
			end

			start     <= drive_item;
			cfg_valid <= drive_cfg;
			if (pending_steps.size() > 0) begin
				head = pending_steps[0];
				req_type      <= head.req;
				table_index   <= head.idx;
				start_key     <= head.skey;
				slope         <= head.slope;
				intercept     <= head.icpt;
				last_position <= head.lpos;
				lookup_key    <= head.lkey;
				cfg_index     <= head.cfg_idx;
				cfg_data      <= head.cfg_data;
			end
		end
	end

	// Monitor: every strobe must meet a waiting prediction.
	range_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			result_count++;
			if (expected_ranges.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing expected: lower %0d upper %0d miss %0b seg %0d",
					$time, lower_position, upper_position, not_found, segment_found);
			end else begin
				want = expected_ranges.pop_front();
				if (lower_position !== want.lower) begin
					error_count++;
					$display("%0t: lower_position expected %0d actual %0d",
						$time, want.lower, lower_position);
				end
				if (upper_position !== want.upper) begin
					error_count++;
					$display("%0t: upper_position expected %0d actual %0d",
						$time, want.upper, upper_position);
				end
				if (not_found !== want.miss) begin
					error_count++;
					$display("%0t: not_found expected %0b actual %0b",
						$time, want.miss, not_found);
				end
				if (segment_found !== want.seg) begin
					error_count++;
					$display("%0t: segment_found expected %0d actual %0d",
						$time, want.seg, segment_found);
				end
			end
		end
	end

	// Watchdog: too long without any transfer or result ends the run.
	int quiet_cycles;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_write(int idx, logic [63:0] k, logic [63:0] sl, logic [63:0] ic,
			logic [31:0] lp);
		step_t s;

		s         = '{kind: STEP_ITEM, default: '0};
		s.kind    = STEP_ITEM;
		s.req     = REQ_WRITE;
		s.idx     = idx[9:0];
		s.skey    = k;
		s.slope   = sl;
		s.icpt    = ic;
		s.lpos    = lp;
		s.lkey    = rand64();
		pending_steps.insert(pending_steps.size(), s);
	endtask

	task automatic push_lookup(logic [63:0] k);
		step_t s;

		s       = '{kind: STEP_ITEM, default: '0};
		s.kind  = STEP_ITEM;
		s.req   = REQ_LOOKUP;
		// The unused fields carry noise that the block must ignore.
		s.idx   = 10'($urandom());
		s.skey  = rand64();
		s.slope = rand64();
		s.icpt  = rand64();
		s.lpos  = $urandom();
		s.lkey  = k;
		pending_steps.insert(pending_steps.size(), s);
	endtask

	task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
		step_t s;

		s          = '{kind: STEP_CFG, default: '0};
		s.kind     = STEP_CFG;
		s.cfg_idx  = idx;
		s.cfg_data = d;
		pending_steps.insert(pending_steps.size(), s);
	endtask

	task automatic push_drain();
		step_t s;

		s      = '{kind: STEP_DRAIN, default: '0};
		s.kind = STEP_DRAIN;
		pending_steps.insert(pending_steps.size(), s);
	endtask

	// Sorted start keys and non-decreasing last positions for the first n entries.
	task automatic plan_keys(int n);
		logic [63:0] k;
		logic [31:0] lp;
		int          sh;

		k  = rand64() >> $urandom_range(2, 63);
		lp = $urandom_range(0, 20);
		sh = $urandom_range(12, 62);
		for (int i = 0; i < n; i++) begin
			plan_key[i]  = k;
			plan_last[i] = lp;
			k  += (rand64() >> sh) + 64'd1;
			lp += $urandom_range(0, 40);
		end
	endtask

	// One segment with a mix of flat, gentle and wild slopes; half of the
	// intercepts aim the prediction at positions around the entry count.
	task automatic push_segment(int i, logic [31:0] entries);
		logic [63:0] sl;
		logic [63:0] ic;

		case ($urandom_range(0, 3))
			0: sl = rand64() >> $urandom_range(40, 63);
			1: sl = rand64() >> $urandom_range(0, 63);
			2: sl = 64'd0;
			default: sl = 64'h0001_0000_0000_0000 >> $urandom_range(0, 40);
		endcase
		case ($urandom_range(0, 3))
			0, 1: ic = (({32'd0, $urandom()} % ({32'd0, entries} + 64'd20)) << FRAC)
				| $urandom_range(0, 65535);
			2: ic = longint'($signed(rand64())) >>> $urandom_range(0, 63);
			default: ic = -longint'($urandom_range(0, 2000000));
		endcase
		push_write(i, plan_key[i], sl, ic, plan_last[i]);
	endtask

	function automatic logic [63:0] pick_key(int n);
		int i;

		i = $urandom_range(0, n - 2);
		case ($urandom_range(0, 9))
			6: return rand64();
			7: return plan_key[i];
			8: return ($urandom_range(0, 1) != 0) ? plan_min : plan_min - 64'd1;
			9: return ($urandom_range(0, 1) != 0) ? plan_max : plan_max + 64'd1;
			default: return plan_key[i] + (rand64() >> $urandom_range(10, 63));
		endcase
	endfunction

	// One setting of the registers: drain, write all of them, reload the
	// segments in use, then look up keys with the odd segment rewrite.
	task automatic run_phase(logic [10:0] segs, logic [31:0] entries, logic [15:0] err,
			bit merged, bit nb, int bounds, int lookups);
		int n;
		int i;

		n = (segs < 2) ? 2 : (segs > MAX_SEGS) ? MAX_SEGS : segs;
		plan_keys(n);
		plan_min = 64'd0;
		plan_max = KEY_ONES;
		if (bounds == 1) begin
			plan_min = plan_key[0];
			plan_max = plan_key[n-1];
		end else if (bounds == 2) begin
			plan_min = plan_key[n/2];
			plan_max = plan_key[n-1] + (rand64() >> 8);
		end
		push_drain();
		push_cfg(CFG_MIN_KEY, plan_min);
		push_cfg(CFG_MAX_KEY, plan_max);
		push_cfg(CFG_ENTRY_CNT, {32'($urandom()), entries});
		push_cfg(CFG_ERR_BOUND, {48'(rand64()), err});
		push_cfg(CFG_SEG_CNT, {53'(rand64()), segs});
		push_cfg(CFG_MERGED, {63'(rand64()), merged});
		push_cfg(CFG_NB_CLAMP, {63'(rand64()), nb});
		for (i = 0; i < n; i++)
			push_segment(i, entries);
		repeat (lookups) begin
			if ($urandom_range(0, 19) == 0)
				push_segment($urandom_range(0, n - 1), entries);
			else
				push_lookup(pick_key(n));
		end
	endtask

	logic [31:0] phase_entries;

	initial begin
		error_count  = 0;
		write_count  = 0;
		lookup_count = 0;
		cfg_count    = 0;
		miss_count   = 0;
		result_count = 0;

		// Directed part under the reset settings: two segments, so every lookup
		// lands on segment 0, one entry and an error bound of 8.
		push_write(MAX_SEGS - 1, KEY_ONES, KEY_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		push_write(MAX_SEGS - 1, 64'd0, 64'd0, 64'h8000_0000_0000_0000, 32'd0);
		push_write(0, 64'd0, 64'd0, 64'd0, 32'd0);
		push_lookup(64'd0);
		push_lookup(KEY_ONES);
		// Steepest slope and largest intercept: the integer part saturates and
		// the lower bound runs past the end.
		push_write(0, 64'd0, KEY_ONES, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		push_lookup(KEY_ONES);
		push_lookup(64'd1);
		// Same overflow with the repair in merged mode.
		push_drain();
		push_cfg(CFG_MERGED, 64'd1);
		push_lookup(KEY_ONES);
		push_drain();
		push_cfg(CFG_MERGED, 64'd0);
		// A prediction far below zero pins both bounds at the bottom.
		push_write(0, 64'd0, 64'd0, -longint'(100 << FRAC), 32'd0);
		push_lookup(64'd5);
		// A fractional prediction equal to the error bound.
		push_write(0, 64'd0, 64'd0, (64'd8 << FRAC) | 64'd1, 32'd0);
		push_lookup(64'd3);
		// Keys just outside and inside the bounds.
		push_drain();
		push_cfg(CFG_MIN_KEY, 64'd100);
		push_cfg(CFG_MAX_KEY, 64'd200);
		push_cfg(CFG_UNUSED, rand64());
		push_lookup(64'd99);
		push_lookup(64'd201);
		push_lookup(64'd150);
		push_lookup(64'd100);
		push_lookup(64'd200);

		// The first phase fills the whole table, so no later lookup can reach
		// an entry that was never written.
		run_phase(11'd2047, 32'd100000, 16'd8, 1'b0, 1'b0, 0, 150);
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 5))
				0: phase_entries = 32'd1;
				1: phase_entries = $urandom_range(2, 300);
				default: phase_entries = $urandom_range(300, 100000);
			endcase
			if (p == 5)
				phase_entries = 32'd0;
			if (p == 6)
				phase_entries = 32'hFFFF_FFFF;
			run_phase((p == 0) ? 11'd0 : (p == 1) ? 11'd1 : (p == 2) ? 11'd3
					: 11'($urandom_range(4, 48)),
				phase_entries,
				(p == 3) ? 16'hFFFF : (p == 4) ? 16'd0 : 16'($urandom_range(0, 40)),
				(p % 3) == 1, (p % 2) == 0, p % 3, 60);
		end
		push_drain();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending_steps.size() != 0 || expected_ranges.size() != 0);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d segment writes, %0d lookups (%0d misses), %0d register writes,",
			write_count, lookup_count, miss_count, cfg_count);
		$display("%0d results checked with %0d mismatches.", result_count, error_count);
		if (error_count == 0 && expected_ranges.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
